@@ rtl/core/hcd_pkg.sv @@
// Shared types and constants for the HTTP chunked body decoder.
// Depends on nothing; hcd_size_acc, the decoder and the bench import it.
package hcd_pkg;

  // Width of the chunk size and remaining byte count
  localparam int unsigned SIZE_BITS = 32;

  localparam logic [7:0] BYTE_CR = 8'h0d;
  localparam logic [7:0] BYTE_LF = 8'h0a;

  // Decoder phases
  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_DATA    = 3'd1,
    PH_CR      = 3'd2,
    PH_LF      = 3'd3,
    PH_SEEK    = 3'd4,
    PH_TRAILER = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  // Commands from the phase logic to the size accumulator
  typedef struct packed {
    logic clear;  // start a new size line
    logic load;   // shift in the current hex digit
  } hcd_size_ctl_t;

  // Status from the size accumulator
  typedef struct packed {
    logic is_hex;   // current byte is a hex digit
    logic is_zero;  // accumulated size is zero
  } hcd_size_sts_t;

endpackage

@@ rtl/core/hcd_in_if.sv @@
// Byte input channel of the chunked decoder: valid/ready plus one raw byte.
// Depends on nothing.
interface hcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

@@ rtl/core/hcd_out_if.sv @@
// Result channel of the chunked decoder: valid/ready plus one decoded result.
// Depends on nothing.
interface hcd_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       message_done;
  logic       format_error;

  modport source (output valid, output payload_valid, output payload_byte,
                  output message_done, output format_error, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input message_done, input format_error, output ready);
endinterface

@@ rtl/core/hcd_size_acc.sv @@
// Chunk size accumulator: hex digit decode and saturating shift-in register.
// Depends on hcd_pkg.
module hcd_size_acc
  import hcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           in_byte,
  input  hcd_size_ctl_t        ctl,
  output hcd_size_sts_t        sts,
  output logic [SIZE_BITS-1:0] chunk_length
);

  logic       is_hex;
  logic [3:0] digit;

  // Decode one ASCII hex digit
  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (in_byte >= "0" && in_byte <= "9") begin
      digit = 4'(in_byte - "0");
    end else if (in_byte >= "a" && in_byte <= "f") begin
      digit = 4'(in_byte - "a" + 8'd10);
    end else if (in_byte >= "A" && in_byte <= "F") begin
      digit = 4'(in_byte - "A" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign sts.is_hex  = is_hex;
  assign sts.is_zero = (chunk_length == '0);

  // Shift in a digit; saturate once the top nibble is occupied
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      chunk_length <= '0;
    end else if (ctl.load) begin
      if (|chunk_length[SIZE_BITS-1:SIZE_BITS-4]) begin
        chunk_length <= '1;
      end else begin
        chunk_length <= {chunk_length[SIZE_BITS-5:0], digit};
      end
    end
  end

endmodule

@@ rtl/core/http_chunked_decoder.sv @@
// HTTP/1.1 chunked body decoder. It takes one byte per transaction on stream
// and gives exactly one result per byte on result, in the next cycle, at a
// rate of one byte per clock unless result stalls. Size lines gather leading
// hex digits (saturating at all ones), chunk data is passed out as payload, a
// missing CRLF/LF after data is flagged with format_error on raw bytes up to
// the next LF, and the empty trailer line raises message_done; later bytes
// give all-zero results. stream.ready is high whenever the result register is
// empty or being taken in the same cycle, so the only stall is backpressure
// on result. Depends on hcd_pkg, hcd_in_if, hcd_out_if and hcd_size_acc.
module http_chunked_decoder
  import hcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  hcd_in_if.sink   stream,
  hcd_out_if.source result
);

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] bytes_left, bytes_left_next;
  logic                 digits_ended, digits_ended_next;
  logic [1:0]           trailer_line_count, trailer_line_count_next;
  logic                 trailer_first_cr, trailer_first_cr_next;
  logic [SIZE_BITS-1:0] chunk_length;
  hcd_size_ctl_t        size_ctl;
  hcd_size_sts_t        size_sts;

  logic       accept;
  logic       res_valid;
  logic       valid_next, done_next, err_next;
  logic [7:0] data_next;
  logic [7:0] b;

  assign b            = stream.in_byte;
  assign stream.ready = !res_valid || result.ready;
  assign accept       = stream.valid && stream.ready;

  hcd_size_acc u_size (
    .clk          (clk),
    .rst          (rst),
    .in_byte      (b),
    .ctl          (size_ctl),
    .sts          (size_sts),
    .chunk_length (chunk_length)
  );

  // Next phase and result for the byte on the input
  always_comb begin
    phase_next              = phase;
    bytes_left_next         = bytes_left;
    digits_ended_next       = digits_ended;
    trailer_line_count_next = trailer_line_count;
    trailer_first_cr_next   = trailer_first_cr;
    size_ctl                = '0;
    valid_next              = 1'b0;
    data_next               = 8'd0;
    done_next               = 1'b0;
    err_next                = 1'b0;
    if (accept) begin
      case (phase)
        PH_SIZE: begin
          if (b == BYTE_LF) begin
            if (size_sts.is_zero) begin
              phase_next              = PH_TRAILER;
              trailer_line_count_next = 2'd0;
              trailer_first_cr_next   = 1'b0;
            end else begin
              bytes_left_next = chunk_length;
              phase_next      = PH_DATA;
            end
          end else if (!digits_ended && size_sts.is_hex) begin
            size_ctl.load = 1'b1;
          end else begin
            digits_ended_next = 1'b1;
          end
        end
        PH_DATA: begin
          valid_next      = 1'b1;
          data_next       = b;
          bytes_left_next = bytes_left - 1'b1;
          if (bytes_left == SIZE_BITS'(1)) begin
            phase_next = PH_CR;
          end
        end
        PH_CR, PH_LF, PH_SEEK: begin
          if (b == BYTE_LF) begin
            phase_next        = PH_SIZE;
            size_ctl.clear    = 1'b1;
            digits_ended_next = 1'b0;
          end else if (b == BYTE_CR && phase == PH_CR) begin
            phase_next = PH_LF;
          end else begin
            valid_next = 1'b1;
            data_next  = b;
            err_next   = 1'b1;
            phase_next = PH_SEEK;
          end
        end
        PH_TRAILER: begin
          if (b == BYTE_LF) begin
            if (trailer_line_count == 2'd0 ||
                (trailer_line_count == 2'd1 && trailer_first_cr)) begin
              done_next  = 1'b1;
              phase_next = PH_DONE;
            end
            trailer_line_count_next = 2'd0;
            trailer_first_cr_next   = 1'b0;
          end else begin
            if (trailer_line_count == 2'd0) begin
              trailer_first_cr_next = (b == BYTE_CR);
            end
            if (trailer_line_count != 2'd3) begin
              trailer_line_count_next = trailer_line_count + 2'd1;
            end
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  // Hold the decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_SIZE;
      bytes_left         <= '0;
      digits_ended       <= 1'b0;
      trailer_line_count <= 2'd0;
      trailer_first_cr   <= 1'b0;
    end else begin
      phase              <= phase_next;
      bytes_left         <= bytes_left_next;
      digits_ended       <= digits_ended_next;
      trailer_line_count <= trailer_line_count_next;
      trailer_first_cr   <= trailer_first_cr_next;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.payload_valid <= valid_next;
      result.payload_byte  <= data_next;
      result.message_done  <= done_next;
      result.format_error  <= err_next;
    end
  end

  assign result.valid = res_valid;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for http_chunked_decoder: a chunk-body byte stream in, one decoded result
// per byte out, checked against a cycle-free prediction of the decoder kept in a small class.
// Depends on hcd_pkg, hcd_in_if, hcd_out_if and the decoder RTL.
module testbench;
  import hcd_pkg::*;

  localparam int unsigned ITEMS_TARGET = 750;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned IDLE_LIMIT   = 2000;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       message_done;
    logic       format_error;
  } hcd_result_t;

  // Predicts the decoder byte by byte and holds the results still owed by it
  class chunk_scoreboard;
    phase_t               phase;
    logic [SIZE_BITS-1:0] chunk_len;
    logic [SIZE_BITS-1:0] bytes_rem;
    bit                   digits_ended;
    bit [1:0]             trl_count;
    bit                   trl_cr;
    hcd_result_t          owed[$];
    int unsigned          n_bytes, n_payload, n_flagged, n_done, n_fail;

    function new();
      phase        = PH_SIZE;
      chunk_len    = '0;
      bytes_rem    = '0;
      digits_ended = 0;
      trl_count    = 0;
      trl_cr       = 0;
    endfunction

    function int hex_digit(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return b - "a" + 10;
      if (b >= "A" && b <= "F") return b - "A" + 10;
      return -1;
    endfunction

    function void begin_size_line();
      phase        = PH_SIZE;
      chunk_len    = '0;
      digits_ended = 0;
    endfunction

    // Advance the prediction by one accepted byte and queue its result
    function void note_byte(logic [7:0] b);
      hcd_result_t          r;
      logic [SIZE_BITS-1:0] max_len;
      int                   hv;
      r       = '0;
      max_len = '1;
      hv      = hex_digit(b);
      n_bytes++;
      case (phase)
        PH_SIZE: begin
          if (b == BYTE_LF) begin
            if (chunk_len == 0) begin
              phase     = PH_TRAILER;
              trl_count = 0;
              trl_cr    = 0;
            end else begin
              bytes_rem = chunk_len;
              phase     = PH_DATA;
            end
          end else if (!digits_ended && hv >= 0) begin
            // saturate once another digit would shift bits out
            if (chunk_len > (max_len >> 4)) chunk_len = max_len;
            else chunk_len = {chunk_len[SIZE_BITS-5:0], hv[3:0]};
          end else begin
            digits_ended = 1;
          end
        end
        PH_DATA: begin
          r.payload_valid = 1;
          r.payload_byte  = b;
          bytes_rem       = bytes_rem - 1'b1;
          if (bytes_rem == 0) phase = PH_CR;
        end
        PH_CR: begin
          if (b == BYTE_CR) phase = PH_LF;
          else if (b == BYTE_LF) begin_size_line();
          else begin
            r = '{1'b1, b, 1'b0, 1'b1};
            phase = PH_SEEK;
          end
        end
        PH_LF, PH_SEEK: begin
          if (b == BYTE_LF) begin_size_line();
          else begin
            r = '{1'b1, b, 1'b0, 1'b1};
            phase = PH_SEEK;
          end
        end
        PH_TRAILER: begin
          if (b == BYTE_LF) begin
            // empty line: nothing, or a lone CR
            if (trl_count == 0 || (trl_count == 1 && trl_cr)) begin
              r.message_done = 1;
              phase          = PH_DONE;
            end
            trl_count = 0;
            trl_cr    = 0;
          end else begin
            if (trl_count == 0) trl_cr = (b == BYTE_CR);
            if (trl_count < 3) trl_count++;
          end
        end
        default: phase = PH_DONE;
      endcase
      if (r.format_error) n_flagged++;
      else if (r.payload_valid) n_payload++;
      if (r.message_done) n_done++;
      owed.push_back(r);
    endfunction

    function void compare_field(string fname, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
        n_fail++;
      end
    endfunction

    // Check one result taken from the decoder against the oldest one owed
    function void check_result(hcd_result_t got);
      hcd_result_t want;
      if (owed.size() == 0) begin
        $error("result 0x%0h arrived with nothing outstanding", got);
        n_fail++;
        return;
      end
      want = owed.pop_front();
      compare_field("payload_valid", 8'(want.payload_valid), 8'(got.payload_valid));
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("message_done", 8'(want.message_done), 8'(got.message_done));
      compare_field("format_error", 8'(want.format_error), 8'(got.format_error));
    endfunction
  endclass

  logic clk;
  logic rst;

  hcd_in_if  stream_if ();
  hcd_out_if result_if ();

  http_chunked_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  chunk_scoreboard tracker = new();

  bit          hold_arm    = 0;
  bit          hold_req    = 0;
  int unsigned gap_cycles  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Offer one byte and hold it until the decoder takes it; plan the next gap
  task automatic send_byte(input logic [7:0] b);
    if (gap_cycles > 0) begin
      repeat (gap_cycles) @(negedge clk);
      gap_cycles = 0;
    end
    stream_if.valid   = 1;
    stream_if.in_byte = b;
    do @(posedge clk); while (!stream_if.ready);
    tracker.note_byte(b);
    if (hold_arm) begin
      hold_req = 1;
      hold_arm = 0;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else if (!hold_req) begin
      gap_cycles = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 16);
    end
    @(negedge clk);
    stream_if.valid = 0;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line_end(input bit bare);
    if (!bare) send_byte(BYTE_CR);
    send_byte(BYTE_LF);
  endtask

  function automatic logic [7:0] rand_byte_except(logic [7:0] a, logic [7:0] c);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == a || b == c);
    return b;
  endfunction

  function automatic logic [7:0] hex_char(int unsigned v);
    if (v < 10) return 8'("0" + v);
    return 8'((($urandom_range(0, 1) != 0) ? "a" : "A") + v - 10);
  endfunction

  // Size line: hex digits (sometimes zero padded), optional extension, CRLF or LF
  task automatic send_size_line(input int unsigned len);
    int          pad;
    bit          started;
    int unsigned nib;
    logic [7:0]  b;
    pad = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
    repeat (pad) send_byte("0");
    started = 0;
    for (int i = 7; i >= 0; i--) begin
      nib = (len >> (4 * i)) & 4'hf;
      if (nib != 0 || started || i == 0) begin
        started = 1;
        send_byte(hex_char(nib));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      // first byte must end the digits; the rest up to LF is ignored
      do b = rand_byte_except(BYTE_LF, BYTE_LF); while (tracker.hex_digit(b) >= 0);
      send_byte(b);
      repeat ($urandom_range(0, 6)) send_byte(rand_byte_except(BYTE_LF, BYTE_LF));
    end
    send_line_end($urandom_range(0, 2) == 0);
  endtask

  // One chunk with random content and a line end that is sometimes broken
  task automatic send_chunk(input int unsigned len);
    int unsigned kind;
    send_size_line(len);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      send_line_end(0);
    end else if (kind < 8) begin
      send_line_end(1);
    end else begin
      // broken end: either no CR at all or a CR followed by junk
      if (kind == 9) send_byte(BYTE_CR);
      send_byte(rand_byte_except(BYTE_CR, BYTE_LF));
      repeat ($urandom_range(0, 4)) send_byte(rand_byte_except(BYTE_LF, BYTE_LF));
      send_byte(BYTE_LF);
    end
  endtask

  // Receiver: rotating stall pattern, plus one long hold-off on request
  initial begin
    int unsigned hold_cnt;
    int unsigned pat_age;
    logic [7:0]  pat;
    hold_cnt        = 0;
    pat_age         = 0;
    pat             = 8'hff;
    result_if.ready = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        result_if.ready = 0;
      end else if (hold_req) begin
        result_if.ready = 0;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) begin
          hold_req = 0;
          hold_cnt = 0;
        end
      end else begin
        if (pat_age == 0) begin
          pat_age = $urandom_range(20, 80);
          case ($urandom_range(0, 2))
            0:       pat = 8'hff;
            1:       pat = 8'($urandom_range(1, 255));
            default: pat = 8'($urandom_range(0, 255) | $urandom_range(0, 255) | 8'h01);
          endcase
        end
        result_if.ready = pat[0];
        pat             = {pat[0], pat[7:1]};
        pat_age--;
      end
    end
  end

  // Take every result handed over and check it
  initial begin
    hcd_result_t got;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready) begin
        got.payload_valid = result_if.payload_valid;
        got.payload_byte  = result_if.payload_byte;
        got.message_done  = result_if.message_done;
        got.format_error  = result_if.format_error;
        tracker.check_result(got);
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  initial begin
    forever begin
      @(posedge clk);
      if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n_chunks;
    int unsigned len;
    rst               = 1;
    stream_if.valid   = 0;
    stream_if.in_byte = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: single zero byte with CRLF
    send_str("1");
    send_line_end(1);
    send_byte(8'h00);
    send_line_end(0);
    // data holding CR and LF, max byte, extension, bare LF end
    send_str("3;x");
    send_line_end(0);
    send_byte(8'hff);
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    send_line_end(1);
    // missing line end: raw bytes flagged up to LF
    send_str("1");
    send_line_end(1);
    send_byte("Q");
    send_byte("x");
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    // CR not followed by LF
    send_str("1");
    send_line_end(1);
    send_byte("A");
    send_byte(BYTE_CR);
    send_byte("z");
    send_byte(BYTE_LF);

    // Random chunks; one long receiver hold-off part way through
    n_chunks = 0;
    while (tracker.n_bytes < ITEMS_TARGET) begin
      if (n_chunks == 12) hold_arm = 1;
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(100, 260);
        1, 2, 3,
        4, 5:    len = $urandom_range(9, 40);
        default: len = $urandom_range(1, 8);
      endcase
      send_chunk(len);
      n_chunks++;
    end

    // Last chunk: "0x" prefix stops the digits, so size is zero and trailer begins
    send_str("0x1F");
    send_line_end(0);
    send_str("Expires: 0");
    send_line_end(0);
    send_byte(BYTE_CR);
    send_line_end(0);
    send_str("A");
    send_line_end(1);
    send_str("\t");
    send_line_end(0);
    // empty line ends the message, then everything is ignored
    send_line_end($urandom_range(0, 1) != 0);
    repeat (12) send_byte(8'($urandom_range(0, 255)));

    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d chunks, %0d bytes in, %0d payload bytes, %0d flagged raw bytes",
             n_chunks + 5, tracker.n_bytes, tracker.n_payload, tracker.n_flagged);
    $display("summary: %0d message end(s) seen, one long receiver hold-off", tracker.n_done);
    if (tracker.n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/hcd_pkg.sv
rtl/core/hcd_in_if.sv
rtl/core/hcd_out_if.sv
rtl/core/hcd_size_acc.sv
rtl/core/http_chunked_decoder.sv
tb/testbench.sv
